/* hw/rtl/ir_pulse_frame_decoder_macros.svh */
// assertion macros for the ir pulse frame decoder
// no dependencies; the files that check their own logic include this header
`ifndef IR_PULSE_FRAME_DECODER_MACROS_SVH
`define IR_PULSE_FRAME_DECODER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication under reset
`define IPFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ipfd assertion failed");
// next-cycle implication under reset
`define IPFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ipfd assertion failed");
`else
`define IPFD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IPFD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/ipfd_pkg.sv */
// types, register indexes and reset values for the ir pulse frame decoder
// no dependencies; used by ipfd_bit_decode and ir_pulse_frame_decoder
package ipfd_pkg;

	localparam int TOTAL_BITS_DEF    = 32;
	localparam int HALF_BITS_DEF     = 16;
	localparam int PERIOD_MARGIN_DEF = 200;

	localparam int TICK_W  = 16;
	localparam int CNT_W   = 6;
	localparam int WORD_W  = 32;
	localparam int BYTE_W  = 8;
	localparam int CIDX_W  = 3;

	typedef enum logic [CIDX_W-1:0] {
		REG_HDR_LOW_MIN    = 3'd0,
		REG_HDR_LOW_MAX    = 3'd1,
		REG_HDR_PERIOD_MIN = 3'd2,
		REG_HDR_PERIOD_MAX = 3'd3,
		REG_MARK_MIN       = 3'd4,
		REG_MARK_MAX       = 3'd5,
		REG_ZERO_PERIOD    = 3'd6,
		REG_ONE_STEP       = 3'd7
	} reg_idx_t;

	localparam logic [TICK_W-1:0] HDR_LOW_MIN_RST    = 16'd8000;
	localparam logic [TICK_W-1:0] HDR_LOW_MAX_RST    = 16'd10000;
	localparam logic [TICK_W-1:0] HDR_PERIOD_MIN_RST = 16'd12500;
	localparam logic [TICK_W-1:0] HDR_PERIOD_MAX_RST = 16'd14500;
	localparam logic [TICK_W-1:0] MARK_MIN_RST       = 16'd400;
	localparam logic [TICK_W-1:0] MARK_MAX_RST       = 16'd700;
	localparam logic [TICK_W-1:0] ZERO_PERIOD_RST    = 16'd1120;
	localparam logic [TICK_W-1:0] ONE_STEP_RST       = 16'd1120;

	typedef struct packed {
		logic              kind;
		logic [TICK_W-1:0] low_ticks;
		logic [TICK_W-1:0] period_ticks;
	} in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] custom_low;
		logic [BYTE_W-1:0] custom_high;
		logic [BYTE_W-1:0] data_low;
		logic [BYTE_W-1:0] data_high;
	} out_t;

	typedef struct packed {
		logic [TICK_W-1:0] header_low_min;
		logic [TICK_W-1:0] header_low_max;
		logic [TICK_W-1:0] header_period_min;
		logic [TICK_W-1:0] header_period_max;
		logic [TICK_W-1:0] mark_min;
		logic [TICK_W-1:0] mark_max;
		logic [TICK_W-1:0] zero_period;
		logic [TICK_W-1:0] one_step;
	} cfg_t;

	// pulse classification handed from the decoder to the frame logic
	typedef struct packed {
		logic hdr_ok;
		logic bit_ok;
		logic bit_val;
	} cls_t;

endpackage

/* hw/rtl/ir_pulse_frame_decoder.sv */
// top level of the ir pulse frame decoder: input register, frame state, result register
// depends on ipfd_pkg, ipfd_bit_decode and ir_pulse_frame_decoder_macros.svh
//
// channel | direction | handshake          | payload
// in      | into      | in_valid/in_stall  | in_t  kind, low_ticks, period_ticks
// out     | out of    | out_valid/out_stall| out_t four frame bytes
// cfg     | into      | cfg_we             | cfg_index, cfg_data
//
// one item per cycle while in_stall is low; an item is registered, then classified and
// applied to the frame state as it leaves the input register; the result is registered.
// arst_n clears the frame state and loads the register defaults.
// a waiting result holds in the output register; the input register keeps
// taking items until it holds one that cannot move past a stalled result.
`include "ir_pulse_frame_decoder_macros.svh"
module ir_pulse_frame_decoder import ipfd_pkg::*; #(
	parameter int TOTAL_BITS    = TOTAL_BITS_DEF,
	parameter int HALF_BITS     = HALF_BITS_DEF,
	parameter int PERIOD_MARGIN = PERIOD_MARGIN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_t               in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_t              out_data,
	input  logic              cfg_we,
	input  reg_idx_t          cfg_index,
	input  logic [TICK_W-1:0] cfg_data
);

	localparam logic [CNT_W-1:0] TOTAL_CNT = CNT_W'(TOTAL_BITS);
	localparam logic [CNT_W-1:0] HALF_CNT  = CNT_W'(HALF_BITS);

	cfg_t              cfg_q;
	logic              valid_s1;
	in_t               item_s1;
	logic              receiving_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] word_q;
	logic              out_valid_q;
	out_t              out_q;

	cls_t              cls;
	logic              hold_s1;
	logic              fire_s1;
	logic              emit;
	logic              receiving_n;
	logic [CNT_W-1:0]  cnt_n;
	logic [WORD_W-1:0] word_n;
	logic [WORD_W-1:0] rev;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_low_min    <= HDR_LOW_MIN_RST;
			cfg_q.header_low_max    <= HDR_LOW_MAX_RST;
			cfg_q.header_period_min <= HDR_PERIOD_MIN_RST;
			cfg_q.header_period_max <= HDR_PERIOD_MAX_RST;
			cfg_q.mark_min          <= MARK_MIN_RST;
			cfg_q.mark_max          <= MARK_MAX_RST;
			cfg_q.zero_period       <= ZERO_PERIOD_RST;
			cfg_q.one_step          <= ONE_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HDR_LOW_MIN:    cfg_q.header_low_min    <= cfg_data;
				REG_HDR_LOW_MAX:    cfg_q.header_low_max    <= cfg_data;
				REG_HDR_PERIOD_MIN: cfg_q.header_period_min <= cfg_data;
				REG_HDR_PERIOD_MAX: cfg_q.header_period_max <= cfg_data;
				REG_MARK_MIN:       cfg_q.mark_min          <= cfg_data;
				REG_MARK_MAX:       cfg_q.mark_max          <= cfg_data;
				REG_ZERO_PERIOD:    cfg_q.zero_period       <= cfg_data;
				REG_ONE_STEP:       cfg_q.one_step          <= cfg_data;
				default: ;
			endcase
		end
	end

	assign hold_s1  = valid_s1 && out_valid_q && out_stall;
	assign fire_s1  = valid_s1 && !hold_s1;
	assign in_stall = hold_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hold_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !hold_s1) begin
			item_s1 <= in_data;
		end
	end

	ipfd_bit_decode #(
		.PERIOD_MARGIN (PERIOD_MARGIN)
	) u_decode (
		.cfg          (cfg_q),
		.low_ticks    (item_s1.low_ticks),
		.period_ticks (item_s1.period_ticks),
		.cls          (cls)
	);

	always_comb begin
		for (int i = 0; i < WORD_W; i++) begin
			rev[i] = word_n[WORD_W-1-i];
		end
	end

	// frame state step
	always_comb begin
		receiving_n = receiving_q;
		cnt_n       = cnt_q;
		word_n      = word_q;
		emit        = 1'b0;
		if (item_s1.kind) begin
			receiving_n = 1'b0;
			cnt_n       = '0;
			word_n      = '0;
		end else if (!receiving_q) begin
			if (cls.hdr_ok) begin
				receiving_n = 1'b1;
			end else begin
				cnt_n  = '0;
				word_n = '0;
			end
		end else if (cls.bit_ok) begin
			word_n = (word_q | WORD_W'(cls.bit_val)) << 1;
			cnt_n  = cnt_q + CNT_W'(1);
			if (cnt_n == TOTAL_CNT) begin
				emit        = 1'b1;
				receiving_n = 1'b0;
			end else if (cnt_n == HALF_CNT) begin
				// second header expected
				receiving_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			cnt_q       <= '0;
			word_q      <= '0;
		end else if (fire_s1) begin
			receiving_q <= receiving_n;
			cnt_q       <= emit ? '0 : cnt_n;
			word_q      <= emit ? '0 : word_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (fire_s1 && emit) || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			out_q.custom_low  <= rev[7:0];
			out_q.custom_high <= rev[15:8];
			out_q.data_low    <= rev[23:16];
			out_q.data_high   <= rev[31:24];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`IPFD_ASSERT_NXT(a_emit_clears, clk, arst_n, fire_s1 && emit, out_valid_q && !receiving_q && (cnt_q == '0))
	`IPFD_ASSERT_NXT(a_hold_keeps_item, clk, arst_n, hold_s1, valid_s1 && $stable(item_s1))
	`IPFD_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q < TOTAL_CNT)

endmodule

/* hw/rtl/ipfd_bit_decode.sv */
// classifies one captured pulse as a good header and/or a data bit
// depends on ipfd_pkg
module ipfd_bit_decode import ipfd_pkg::*; #(
	parameter int PERIOD_MARGIN = PERIOD_MARGIN_DEF
) (
	input  cfg_t              cfg,
	input  logic [TICK_W-1:0] low_ticks,
	input  logic [TICK_W-1:0] period_ticks,
	output cls_t              cls
);

	localparam int EXT_W = TICK_W + 2;
	localparam logic [EXT_W-1:0] MARGIN = EXT_W'(PERIOD_MARGIN[TICK_W-1:0]);

	function automatic logic fits(input logic [EXT_W-1:0] period, input logic [EXT_W-1:0] center);
		logic [EXT_W-1:0] lo;
		logic [EXT_W-1:0] hi;
		begin
			// lower bound saturates at zero
			lo = (center > MARGIN) ? (center - MARGIN) : '0;
			hi = center + MARGIN;
			return (period >= lo) && (period <= hi);
		end
	endfunction

	logic [EXT_W-1:0] period_x;
	logic [EXT_W-1:0] zero_c;
	logic [EXT_W-1:0] one_c;
	logic             mark_ok;
	logic             fit0;
	logic             fit1;

	always_comb begin
		period_x = EXT_W'(period_ticks);
		zero_c   = EXT_W'(cfg.zero_period);
		one_c    = EXT_W'(cfg.zero_period) + EXT_W'(cfg.one_step);
		mark_ok  = (low_ticks >= cfg.mark_min) && (low_ticks <= cfg.mark_max);
		fit0     = fits(period_x, zero_c);
		fit1     = fits(period_x, one_c);

		cls.hdr_ok  = (low_ticks >= cfg.header_low_min) && (low_ticks <= cfg.header_low_max)
			&& (period_ticks >= cfg.header_period_min)
			&& (period_ticks <= cfg.header_period_max);
		cls.bit_ok  = mark_ok && (fit0 || fit1);
		// zero wins where the two windows overlap
		cls.bit_val = !fit0;
	end

endmodule
